>>> design/stdt_pkg.sv
// Shared widths, codes and the divider cell payload for the Student-t derivative unit.
package stdt_pkg;

  localparam int IN_W   = 24;
  localparam int CFG_W  = 24;
  localparam int MAG_W  = 24;   // |y - f| fits in 24 bits
  localparam int SQ_W   = 48;   // r^2 and the numerator factors
  localparam int A_W    = 49;   // a = r^2 + s
  localparam int A2_W   = 98;   // a^2
  localparam int PROD_W = 96;   // numerator before the Q shift
  localparam int NUM_W  = 137;  // shifted numerator
  localparam int DEN_W  = 147;  // a^3 at most
  localparam int QUO_W  = 32;
  localparam int NHI_W  = NUM_W - QUO_W;
  localparam int NCELL  = QUO_W;
  localparam int PP_W   = 50;
  localparam int OUT_W  = 32;

  localparam logic [1:0] ORD_FIRST  = 2'd0;
  localparam logic [1:0] ORD_SECOND = 2'd1;
  localparam logic [1:0] ORD_THIRD  = 2'd2;
  localparam logic [1:0] ORD_NONE   = 2'd3;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  localparam logic [CFG_W-1:0] SCALE_RESET = 24'd4096;
  localparam logic [CFG_W-1:0] GAIN_RESET  = 24'd12288;

  localparam int SH_FIRST  = 16;
  localparam int SH_SECOND = 28;
  localparam int SH_THIRD  = 41;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] nlow;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             over;
    logic             zero;
  } div_t;

endpackage

>>> design/stdt_if.sv
// Stream interfaces for items entering and results leaving the unit.
interface stdt_req_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] label_value;
  logic signed [23:0] latent_value;
  logic [1:0]  func;
  modport source (output valid, output label_value, output latent_value, output func,
                  input ready);
  modport sink (input valid, input label_value, input latent_value, input func,
                output ready);
endinterface

interface stdt_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] deriv_value;
  logic        saturated;
  modport source (output valid, output deriv_value, output saturated, input ready);
  modport sink (input valid, input deriv_value, input saturated, output ready);
endinterface

>>> design/stdt_front.sv
// Front pipeline: residual, squares, numerator and denominator products, overflow check.
module stdt_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [23:0]               scale_term,
  input  logic [23:0]               gain_term,
  stdt_req_if.sink                  req,
  input  logic                      down_ready,
  output logic                      out_valid,
  output stdt_pkg::div_t            dout
);

  logic en0, en1, en2, en3, en4, en5, en6, en7;
  logic v0, v1, v2, v3, v4, v5, v6;

  assign en7 = !out_valid || down_ready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign req.ready = en0;

  // Stage 0: residual magnitude and sign.
  logic signed [24:0] r_c;
  logic [24:0] rabs_c;
  logic [stdt_pkg::MAG_W-1:0] s0_rmag;
  logic s0_rneg;
  logic [1:0] s0_ord;

  assign r_c = {req.label_value[23], req.label_value}
             - {req.latent_value[23], req.latent_value};
  assign rabs_c = r_c[24] ? -r_c : r_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && req.valid) begin
      s0_rmag <= rabs_c[stdt_pkg::MAG_W-1:0];
      s0_rneg <= r_c[24];
      s0_ord  <= req.func;
    end
  end

  // Stage 1: r^2 and g*|r|.
  logic [stdt_pkg::SQ_W-1:0] r2_c, gr_c, s1_r2, s1_gr;
  logic s1_rneg;
  logic [1:0] s1_ord;

  assign r2_c = s0_rmag * s0_rmag;
  assign gr_c = gain_term * s0_rmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      s1_r2   <= r2_c;
      s1_gr   <= gr_c;
      s1_rneg <= s0_rneg;
      s1_ord  <= s0_ord;
    end
  end

  // Stage 2: a, the signed numerator terms and operand selection.
  logic [35:0] sh_c;
  logic [37:0] sh3_c;
  logic [stdt_pkg::A_W-1:0] a_c;
  logic signed [49:0] b_c, c_c, babs_c, cabs_c;
  logic [stdt_pkg::SQ_W-1:0] x_c, y_c;
  logic [stdt_pkg::A_W-1:0] a1_c;
  logic neg_c;

  assign sh_c  = {scale_term, 12'd0};
  assign sh3_c = {1'b0, sh_c, 1'b0} + {2'b00, sh_c};
  assign a_c   = {1'b0, s1_r2} + {13'd0, sh_c};
  assign b_c   = $signed({2'b00, s1_r2}) - $signed({14'd0, sh_c});
  assign c_c   = $signed({2'b00, s1_r2}) - $signed({12'd0, sh3_c});
  assign babs_c = b_c[49] ? -b_c : b_c;
  assign cabs_c = c_c[49] ? -c_c : c_c;

  always_comb begin
    x_c   = s1_gr;
    y_c   = stdt_pkg::SQ_W'(1);
    a1_c  = stdt_pkg::A_W'(1);
    neg_c = s1_rneg;
    case (s1_ord)
      stdt_pkg::ORD_FIRST: begin
        x_c   = s1_gr;
        y_c   = stdt_pkg::SQ_W'(1);
        a1_c  = stdt_pkg::A_W'(1);
        neg_c = s1_rneg;
      end
      stdt_pkg::ORD_SECOND: begin
        x_c   = babs_c[stdt_pkg::SQ_W-1:0];
        y_c   = {24'd0, gain_term};
        a1_c  = a_c;
        neg_c = b_c[49];
      end
      stdt_pkg::ORD_THIRD: begin
        x_c   = cabs_c[stdt_pkg::SQ_W-1:0];
        y_c   = s1_gr;
        a1_c  = a_c;
        neg_c = s1_rneg ^ c_c[49];
      end
      default: begin
        x_c   = '0;
        y_c   = '0;
        a1_c  = stdt_pkg::A_W'(1);
        neg_c = 1'b0;
      end
    endcase
  end

  logic [stdt_pkg::SQ_W-1:0] s2_x, s2_y;
  logic [stdt_pkg::A_W-1:0] s2_a, s2_a1;
  logic s2_neg, s2_zero;
  logic [1:0] s2_ord;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_x    <= x_c;
      s2_y    <= y_c;
      s2_a    <= a_c;
      s2_a1   <= a1_c;
      s2_neg  <= neg_c;
      s2_zero <= (s1_ord == stdt_pkg::ORD_NONE) || (a_c == '0);
      s2_ord  <= s1_ord;
    end
  end

  // Stage 3: partial products of x*y and a*a1.
  logic [47:0] pp0, pp1, pp2, pp3;
  logic [49:0] qq0;
  logic [48:0] qq1, qq2;
  logic [47:0] qq3;
  logic [stdt_pkg::A_W-1:0] s3_a;
  logic s3_neg, s3_zero;
  logic [1:0] s3_ord;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      pp0 <= s2_x[23:0] * s2_y[23:0];
      pp1 <= s2_x[23:0] * s2_y[47:24];
      pp2 <= s2_x[47:24] * s2_y[23:0];
      pp3 <= s2_x[47:24] * s2_y[47:24];
      qq0 <= s2_a[24:0] * s2_a1[24:0];
      qq1 <= s2_a[24:0] * s2_a1[48:25];
      qq2 <= s2_a[48:25] * s2_a1[24:0];
      qq3 <= s2_a[48:25] * s2_a1[48:25];
      s3_a    <= s2_a;
      s3_neg  <= s2_neg;
      s3_zero <= s2_zero;
      s3_ord  <= s2_ord;
    end
  end

  // Stage 4: sum the partial products.
  logic [stdt_pkg::PROD_W-1:0] num_c, s4_num;
  logic [stdt_pkg::A2_W-1:0] a2_c, s4_a2;
  logic [stdt_pkg::A_W-1:0] s4_m;
  logic s4_neg, s4_zero;
  logic [1:0] s4_ord;

  assign num_c = stdt_pkg::PROD_W'(pp0) + (stdt_pkg::PROD_W'(pp1) << 24)
               + (stdt_pkg::PROD_W'(pp2) << 24) + (stdt_pkg::PROD_W'(pp3) << 48);
  assign a2_c  = stdt_pkg::A2_W'(qq0) + (stdt_pkg::A2_W'(qq1) << 25)
               + (stdt_pkg::A2_W'(qq2) << 25) + (stdt_pkg::A2_W'(qq3) << 50);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      s4_num  <= num_c;
      s4_a2   <= a2_c;
      s4_m    <= (s3_ord == stdt_pkg::ORD_THIRD) ? s3_a : stdt_pkg::A_W'(1);
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      s4_ord  <= s3_ord;
    end
  end

  // Stage 5: partial products of a^2 * m, four chunks by two.
  logic [stdt_pkg::PP_W-1:0] p5 [8];
  logic [stdt_pkg::PROD_W-1:0] s5_num;
  logic s5_neg, s5_zero;
  logic [1:0] s5_ord;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      p5[0] <= s4_a2[24:0] * s4_m[24:0];
      p5[1] <= s4_a2[24:0] * s4_m[48:25];
      p5[2] <= s4_a2[49:25] * s4_m[24:0];
      p5[3] <= s4_a2[49:25] * s4_m[48:25];
      p5[4] <= s4_a2[74:50] * s4_m[24:0];
      p5[5] <= s4_a2[74:50] * s4_m[48:25];
      p5[6] <= s4_a2[97:75] * s4_m[24:0];
      p5[7] <= s4_a2[97:75] * s4_m[48:25];
      s5_num  <= s4_num;
      s5_neg  <= s4_neg;
      s5_zero <= s4_zero;
      s5_ord  <= s4_ord;
    end
  end

  // Stage 6: denominator sum and numerator alignment.
  logic [stdt_pkg::DEN_W-1:0] den_c, s6_den;
  logic [stdt_pkg::NUM_W-1:0] nsh_c, s6_num;
  logic s6_neg, s6_zero;

  assign den_c = stdt_pkg::DEN_W'(p5[0])
               + (stdt_pkg::DEN_W'(p5[1]) << 25) + (stdt_pkg::DEN_W'(p5[2]) << 25)
               + (stdt_pkg::DEN_W'(p5[3]) << 50) + (stdt_pkg::DEN_W'(p5[4]) << 50)
               + (stdt_pkg::DEN_W'(p5[5]) << 75) + (stdt_pkg::DEN_W'(p5[6]) << 75)
               + (stdt_pkg::DEN_W'(p5[7]) << 100);

  always_comb begin
    case (s5_ord)
      stdt_pkg::ORD_FIRST:  nsh_c = stdt_pkg::NUM_W'(s5_num) << stdt_pkg::SH_FIRST;
      stdt_pkg::ORD_SECOND: nsh_c = stdt_pkg::NUM_W'(s5_num) << stdt_pkg::SH_SECOND;
      stdt_pkg::ORD_THIRD:  nsh_c = stdt_pkg::NUM_W'(s5_num) << stdt_pkg::SH_THIRD;
      default:              nsh_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6 && v5) begin
      s6_den  <= den_c;
      s6_num  <= nsh_c;
      s6_neg  <= s5_neg;
      s6_zero <= s5_zero;
    end
  end

  // Stage 7: a quotient of 2^32 or more saturates whatever the sign, so the
  // upper numerator bits only need one compare against the denominator.
  logic [stdt_pkg::DEN_W-1:0] nhi_c;
  assign nhi_c = stdt_pkg::DEN_W'(s6_num[stdt_pkg::NUM_W-1:stdt_pkg::QUO_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en7) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en7 && v6) begin
      dout.rem  <= nhi_c;
      dout.den  <= s6_den;
      dout.nlow <= s6_num[stdt_pkg::QUO_W-1:0];
      dout.quo  <= '0;
      dout.neg  <= s6_neg;
      dout.over <= nhi_c >= s6_den;
      dout.zero <= s6_zero;
    end
  end

endmodule

>>> design/stdt_div_cell.sv
// One restoring-division cell: shifts in a numerator bit and retires one quotient bit.
module stdt_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  stdt_pkg::div_t din,
  output logic           up_ready,
  output logic           out_valid,
  output stdt_pkg::div_t dout,
  input  logic           down_ready
);

  logic [stdt_pkg::DEN_W:0] trial;
  logic [stdt_pkg::DEN_W:0] diff;
  logic                     ge;

  assign up_ready = !out_valid || down_ready;
  assign trial    = {din.rem, din.nlow[stdt_pkg::QUO_W-1]};
  assign ge       = trial >= {1'b0, din.den};
  assign diff     = trial - {1'b0, din.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      dout.rem  <= ge ? diff[stdt_pkg::DEN_W-1:0] : trial[stdt_pkg::DEN_W-1:0];
      dout.den  <= din.den;
      dout.nlow <= {din.nlow[stdt_pkg::QUO_W-2:0], 1'b0};
      dout.quo  <= {din.quo[stdt_pkg::QUO_W-2:0], ge};
      dout.neg  <= din.neg;
      dout.over <= din.over;
      dout.zero <= din.zero;
    end
  end

endmodule

>>> design/student_t_lik_f_derivatives_top.sv
// Top level: configuration registers, front pipeline, divider cell row and rounding stage.
// An accepted item passes through 8 front stages, 32 divider cells and one rounding
// and saturation stage. Throughput: one item per cycle while the output is not stalled,
// set by the row of divider cells that retires one quotient bit per cell. Any stage
// holds only while the stage after it is full and stalled. Reset (synchronous) empties
// all stages and loads scale_term = 1.0 and gain_term = 3.0.
module student_t_lik_f_derivatives_top (
  input  logic        clk,
  input  logic        rst,
  stdt_req_if.sink    req,
  stdt_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [23:0] scale_term;
  logic [23:0] gain_term;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == stdt_pkg::REG_GAIN) ? {8'd0, gain_term} : {8'd0, scale_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_term <= stdt_pkg::SCALE_RESET;
      gain_term  <= stdt_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == stdt_pkg::REG_SCALE) begin
        scale_term <= pwdata[23:0];
      end else begin
        gain_term <= pwdata[23:0];
      end
    end
  end

  stdt_pkg::div_t link  [stdt_pkg::NCELL+1];
  logic           lvld  [stdt_pkg::NCELL+1];
  logic           rdy   [stdt_pkg::NCELL+1];

  stdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .scale_term (scale_term),
    .gain_term  (gain_term),
    .req        (req),
    .down_ready (rdy[0]),
    .out_valid  (lvld[0]),
    .dout       (link[0])
  );

  for (genvar k = 0; k < stdt_pkg::NCELL; k++) begin : g_cell
    stdt_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (lvld[k]),
      .din        (link[k]),
      .up_ready   (rdy[k]),
      .out_valid  (lvld[k+1]),
      .dout       (link[k+1]),
      .down_ready (rdy[k+1])
    );
  end

  // Round to nearest with ties away from zero: bump when twice the remainder
  // reaches the denominator.
  stdt_pkg::div_t fin;
  logic           bump;
  logic [32:0]    qr;
  logic [31:0]    val_c;
  logic           sat_c;

  assign fin  = link[stdt_pkg::NCELL];
  assign bump = {fin.rem, 1'b0} >= {1'b0, fin.den};
  assign qr   = {1'b0, fin.quo} + {32'd0, bump};
  assign rdy[stdt_pkg::NCELL] = !rsp.valid || rsp.ready;

  always_comb begin
    val_c = '0;
    sat_c = 1'b0;
    if (fin.zero) begin
      val_c = '0;
      sat_c = 1'b0;
    end else if (fin.neg) begin
      if (fin.over || qr > 33'h080000000) begin
        val_c = 32'h80000000;
        sat_c = 1'b1;
      end else begin
        val_c = -qr[31:0];
      end
    end else begin
      if (fin.over || qr > 33'h07FFFFFFF) begin
        val_c = 32'h7FFFFFFF;
        sat_c = 1'b1;
      end else begin
        val_c = qr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rdy[stdt_pkg::NCELL]) begin
      rsp.valid <= lvld[stdt_pkg::NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[stdt_pkg::NCELL] && lvld[stdt_pkg::NCELL]) begin
      rsp.deriv_value <= val_c;
      rsp.saturated   <= sat_c;
    end
  end

endmodule
